// ----- hw/rtl/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg: shared constants and types for the point-in-polygon block
// Vertex store sizing, command codes and the structs that pass between the
// sequencer, the vertex store and the edge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int MIN_RING     = 3;

   localparam int COORD_W  = 32;
   localparam int CMD_W    = 2;
   localparam int VTOTAL_W = 9;
   localparam int ADDR_W   = $clog2(MAX_VERTICES);
   localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
   localparam int ISS_W    = $clog2(MAX_VERTICES + 2);
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TEST   = 2'd2;

   typedef struct packed {
      logic                      en;
      logic [ADDR_W-1:0]         addr;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } wr_req_type;

   typedef struct packed {
      logic              en;
      logic              first;
      logic [ADDR_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic                      vld;
      logic                      first;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } vtx_type;

endpackage

`default_nettype wire

// ----- hw/rtl/pip_if.sv -----
// ----------------------------------------------------------------------------
// pip_if: channel interfaces of the point-in-polygon block
// Command channel, result channel and register write channel, each with
// valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;

   modport source (output valid, output cmd, output coord_x, output coord_y, input ready);
   modport sink   (input valid, input cmd, input coord_x, input coord_y, output ready);
endinterface

interface pip_rsp_if;
   logic       valid;
   logic       ready;
   logic       inside_res;
   logic       overflow;
   logic [8:0] vertex_total;

   modport source (output valid, output inside_res, output overflow, output vertex_total,
                   input ready);
   modport sink   (input valid, input inside_res, input overflow, input vertex_total,
                   output ready);
endinterface

interface pip_csr_if;
   logic valid;
   logic ready;
   logic ring_closed;

   modport source (output valid, output ring_closed, input ready);
   modport sink   (input valid, input ring_closed, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pip_store.sv -----
// ----------------------------------------------------------------------------
// pip_store: vertex memory
// One write port and one registered read port over the x and y coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_store import pip_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  wr_req_type wr_req,
   input  rd_req_type rd_req,
   output vtx_type    rd_vtx
);

   logic signed [COORD_W-1:0] x_mem [MAX_VERTICES];
   logic signed [COORD_W-1:0] y_mem [MAX_VERTICES];

   logic                      vld_ff;
   logic                      first_ff;
   logic signed [COORD_W-1:0] x_ff;
   logic signed [COORD_W-1:0] y_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         x_mem[wr_req.addr] <= wr_req.x;
         y_mem[wr_req.addr] <= wr_req.y;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_mem[rd_req.addr];
      y_ff     <= y_mem[rd_req.addr];
      first_ff <= rd_req.first;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= rd_req.en;
      end
   end

   assign rd_vtx = '{vld: vld_ff, first: first_ff, x: x_ff, y: y_ff};

endmodule

`default_nettype wire

// ----- hw/rtl/pip_edge_unit.sv -----
// ----------------------------------------------------------------------------
// pip_edge_unit: edge crossing unit
// Takes the vertex stream one vertex a cycle, pairs each vertex with the one
// before it and folds the ray crossing of that edge into the parity.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge_unit import pip_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [COORD_W-1:0] px,
   input  logic signed [COORD_W-1:0] py,
   input  vtx_type                   vtx,
   output logic                      busy,
   output logic                      parity
);

   logic signed [COORD_W-1:0] prev_x_ff;
   logic signed [COORD_W-1:0] prev_y_ff;

   // stage A: differences
   logic                     a_vld_ff;
   logic                     a_cross_ff;
   logic signed [DIFF_W-1:0] a_dxp_ff;
   logic signed [DIFF_W-1:0] a_dy_ff;
   logic signed [DIFF_W-1:0] a_dxe_ff;
   logic signed [DIFF_W-1:0] a_dyp_ff;

   // stage B: products
   logic                     b_vld_ff;
   logic                     b_cross_ff;
   logic                     b_dyneg_ff;
   logic signed [PROD_W-1:0] b_l_ff;
   logic signed [PROD_W-1:0] b_r_ff;

   logic                     parity_ff;

   logic                     a_cross_in;
   logic signed [DIFF_W-1:0] ax_ext, ay_ext, bx_ext, by_ext, px_ext, py_ext;
   logic signed [PROD_W-1:0] b_l_in;
   logic signed [PROD_W-1:0] b_r_in;
   logic                     left_in;

   always_comb begin
      ax_ext = {vtx.x[COORD_W-1], vtx.x};
      ay_ext = {vtx.y[COORD_W-1], vtx.y};
      bx_ext = {prev_x_ff[COORD_W-1], prev_x_ff};
      by_ext = {prev_y_ff[COORD_W-1], prev_y_ff};
      px_ext = {px[COORD_W-1], px};
      py_ext = {py[COORD_W-1], py};
      // half-open rule: exactly one endpoint strictly above the point
      a_cross_in = (vtx.y > py) != (prev_y_ff > py);
   end

   assign b_l_in = a_dxp_ff * a_dy_ff;
   assign b_r_in = a_dxe_ff * a_dyp_ff;

   // an edge whose y difference (previous minus current) is negative flips the sense of the compare
   assign left_in = b_dyneg_ff ? (b_l_ff > b_r_ff) : (b_l_ff < b_r_ff);

   always_ff @(posedge clock) begin
      if (vtx.vld) begin
         prev_x_ff <= vtx.x;
         prev_y_ff <= vtx.y;
      end
      a_cross_ff <= a_cross_in;
      a_dxp_ff   <= px_ext - ax_ext;
      a_dy_ff    <= by_ext - ay_ext;
      a_dxe_ff   <= bx_ext - ax_ext;
      a_dyp_ff   <= py_ext - ay_ext;
      b_cross_ff <= a_cross_ff;
      b_dyneg_ff <= a_dy_ff[DIFF_W-1];
      b_l_ff     <= b_l_in;
      b_r_ff     <= b_r_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff  <= 1'b0;
         b_vld_ff  <= 1'b0;
         parity_ff <= 1'b0;
      end else begin
         // the first vertex only primes the previous-vertex register
         a_vld_ff <= vtx.vld && !vtx.first;
         b_vld_ff <= a_vld_ff;
         if (start) begin
            parity_ff <= 1'b0;
         end else if (b_vld_ff && b_cross_ff && left_in) begin
            parity_ff <= !parity_ff;
         end
      end
   end

   assign busy   = a_vld_ff || b_vld_ff;
   assign parity = parity_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/point_in_polygon_even_odd.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_even_odd: even-odd ray casting test over one stored ring
// Sequencer, vertex store and edge unit; clear, append and test commands.
// ----------------------------------------------------------------------------
// Clear and append: the result passes through the DONE state into the output
//   register; a new item is taken only when the block is back in idle.
// Test on n >= 3 vertices of a closed ring: the result is set by the walk of
//   n + 1 reads through the single memory read port, one edge per cycle
//   through the edge unit. Other tests go to the DONE state without a walk.
// Reset clears the vertex count, sets ring_closed to 1 and empties the result
//   register; the vertex memory keeps its contents and needs no clearing pass.
`default_nettype none

module point_in_polygon_even_odd import pip_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   pip_req_if.sink          req_chan,
   pip_rsp_if.source        rsp_chan,
   pip_csr_if.sink          csr_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type                 state_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      ring_closed_ff;
   logic signed [COORD_W-1:0] px_ff;
   logic signed [COORD_W-1:0] py_ff;
   logic [ISS_W-1:0]          iss_ff;
   logic                      res_inside_ff;
   logic                      res_ovf_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_inside_ff;
   logic                      rsp_ovf_ff;
   logic [VTOTAL_W-1:0]       rsp_total_ff;

   logic       req_acc;
   logic       all_issued;
   logic       run_done;
   logic       store_full;
   logic       edge_start;
   logic       edge_busy;
   logic       edge_parity;
   wr_req_type wr_req;
   rd_req_type rd_req;
   vtx_type    rd_vtx;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_acc        = req_chan.valid && req_chan.ready;

   assign store_full = (count_ff >= CNT_W'(MAX_VERTICES));
   assign all_issued = (iss_ff == ISS_W'(count_ff) + ISS_W'(1));
   assign run_done   = (state_ff == ST_RUN) && all_issued && !rd_vtx.vld && !edge_busy;
   assign edge_start = req_acc && (req_chan.cmd == CMD_TEST);

   always_comb begin
      wr_req.en   = req_acc && (req_chan.cmd == CMD_APPEND) && !store_full;
      wr_req.addr = ADDR_W'(count_ff);
      wr_req.x    = req_chan.coord_x;
      wr_req.y    = req_chan.coord_y;

      // last vertex first, then 0 .. n-1, so edge i pairs with i-1
      rd_req.en    = (state_ff == ST_RUN) && !all_issued;
      rd_req.first = (iss_ff == '0);
      rd_req.addr  = (iss_ff == '0) ? ADDR_W'(count_ff - CNT_W'(1))
                                    : ADDR_W'(iss_ff - ISS_W'(1));
   end

   pip_store u_store (
      .clock  (clock),
      .reset  (reset),
      .wr_req (wr_req),
      .rd_req (rd_req),
      .rd_vtx (rd_vtx)
   );

   pip_edge_unit u_edge (
      .clock  (clock),
      .reset  (reset),
      .start  (edge_start),
      .px     (px_ff),
      .py     (py_ff),
      .vtx    (rd_vtx),
      .busy   (edge_busy),
      .parity (edge_parity)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         ring_closed_ff <= 1'b1;
         iss_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            ring_closed_ff <= csr_chan.ring_closed;
         end
         // drop the item once taken, unless a new one is loaded behind it
         if (rsp_valid_ff && rsp_chan.ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  px_ff         <= req_chan.coord_x;
                  py_ff         <= req_chan.coord_y;
                  res_inside_ff <= 1'b0;
                  res_ovf_ff    <= (req_chan.cmd == CMD_APPEND) && store_full;
                  iss_ff        <= '0;
                  if ((req_chan.cmd == CMD_TEST) && ring_closed_ff &&
                      count_ff >= CNT_W'(MIN_RING)) begin
                     state_ff <= ST_RUN;
                  end else begin
                     state_ff <= ST_DONE;
                  end
                  case (req_chan.cmd)
                     CMD_CLEAR: begin
                        count_ff <= '0;
                     end
                     CMD_APPEND: begin
                        if (!store_full) begin
                           count_ff <= count_ff + CNT_W'(1);
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_RUN: begin
               if (rd_req.en) begin
                  iss_ff <= iss_ff + ISS_W'(1);
               end
               if (run_done) begin
                  res_inside_ff <= edge_parity;
                  state_ff      <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hold the result until the output register is free
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_inside_ff <= res_inside_ff;
                  rsp_ovf_ff    <= res_ovf_ff;
                  rsp_total_ff  <= VTOTAL_W'(count_ff);
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.inside_res   = rsp_inside_ff;
   assign rsp_chan.overflow     = rsp_ovf_ff;
   assign rsp_chan.vertex_total = rsp_total_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count beyond store depth");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_chan.cmd == CMD_CLEAR |=> count_ff == '0)
      else $error("clear did not empty the ring");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> iss_ff <= ISS_W'(count_ff) + ISS_W'(1))
      else $error("edge walk read past the ring");

   a_result_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_inside_ff && rsp_ovf_ff))
      else $error("inside and overflow both set");

   a_no_read_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |=> !rd_vtx.vld)
      else $error("memory read outside a test");

endmodule

`default_nettype wire
